@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/gole_pkg.sv @@
// ----------------------------------------------------------------------------
// gole_pkg
// shared types of the grid order level engine
// ----------------------------------------------------------------------------
`default_nettype none

package gole_pkg;

   // width of the configuration register index
   localparam int CSR_INDEX_BITS = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOWER   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UPPER   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPACING = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMOUNT  = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_BUY  = 2'd0;
   localparam logic [1:0] KIND_SELL = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // classified command handed from front to back
   typedef struct packed {
      logic is_fill;   // fill report, otherwise market tick
      logic sell;      // fill side is sell
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/gole_front.sv @@
// ----------------------------------------------------------------------------
// gole_front
// accepts request items, drops ignored ones and queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module gole_front #(
   parameter int PRICE_BITS = 40,
   parameter int LW         = 5,
   parameter int CW         = 6
) (
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  in_mode,
   input  wire logic [PRICE_BITS-1:0] in_price,
   input  wire logic                  in_fill_side,
   input  wire logic [6:0]            in_fill_level,
   input  wire logic [PRICE_BITS-1:0] grid_lower,
   input  wire logic [PRICE_BITS-1:0] grid_upper,
   input  wire logic [CW-1:0]         level_total,
   input  wire logic                  q_full,
   output logic                       q_push,
   output gole_pkg::cmd_type          q_cmd,
   output logic [LW-1:0]              q_level,
   output logic [PRICE_BITS-1:0]      q_price
);

   logic accept;
   logic tick_ok;
   logic fill_ok;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // tick must be nonzero and inside the grid range
   assign tick_ok = (in_price != '0) && (in_price >= grid_lower) &&
                    (in_price <= grid_upper);
   // fill must address an existing level
   assign fill_ok = in_fill_level < 7'(level_total);

   assign q_push       = accept && (in_mode ? fill_ok : tick_ok);
   assign q_cmd.is_fill = in_mode;
   assign q_cmd.sell    = in_fill_side;
   assign q_level       = in_fill_level[LW-1:0];
   assign q_price       = in_price;

endmodule

`default_nettype wire

@@ rtl/gole_queue.sv @@
// ----------------------------------------------------------------------------
// gole_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gole_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty,
   output logic                  full
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign dout  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_no_overflow, clock, reset, full, !push)
   `ASSERT_IMPLIES(a_no_underflow, clock, reset, empty, !pop)

endmodule

`default_nettype wire

@@ rtl/gole_back.sv @@
// ----------------------------------------------------------------------------
// gole_back
// executes fills; walks a tick's levels one a cycle while the output is free
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gole_back #(
   parameter int MAX_LEVELS = 32,
   parameter int PRICE_BITS = 40,
   parameter int LW         = 5,
   parameter int CW         = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire gole_pkg::cmd_type     q_cmd,
   input  wire logic [LW-1:0]         q_level,
   input  wire logic [PRICE_BITS-1:0] q_price,
   output logic                       q_pop,
   input  wire logic [PRICE_BITS-1:0] grid_lower,
   input  wire logic [PRICE_BITS-1:0] grid_spacing,
   input  wire logic [23:0]           grid_lot,
   input  wire logic [CW-1:0]         level_total,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_last,
   output logic [4:0]                 rsp_level_index,
   output logic [PRICE_BITS-1:0]      rsp_order_price,
   output logic [23:0]                rsp_quantity,
   output logic [63:0]                rsp_total_profit,
   output logic [31:0]                rsp_total_trades
);

   localparam int EW = PRICE_BITS + 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINAL
   } state_type;

   state_type             state_ff;
   logic [MAX_LEVELS-1:0] held_ff;
   logic                  active_ff;
   logic                  init_ff;
   logic [63:0]           profit_ff;
   logic [31:0]           trades_ff;
   logic [63:0]           gain_ff;
   logic [PRICE_BITS-1:0] px_ff;
   logic [EW-1:0]         lp_ff;
   logic [CW-1:0]         idx_ff;

   logic                  rsp_tvalid_ff;
   logic [1:0]            kind_ff;
   logic                  last_ff;
   logic [4:0]            level_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [23:0]           qty_ff;
   logic [63:0]           prof_out_ff;
   logic [31:0]           trad_out_ff;

   logic          slot_free;
   logic          rsp_load;
   logic [LW-1:0] cur_idx;
   logic [CW-1:0] idx_next;
   logic [EW-1:0] px_wide;
   logic [EW-1:0] up_price;
   logic          held_now;
   logic          emit_sell;
   logic          emit_buy;
   logic [64:0]   profit_sum;

   function automatic logic [PRICE_BITS-1:0] sat_price(input logic [EW-1:0] v);
      if (|v[EW-1:PRICE_BITS]) begin
         return '1;
      end
      return v[PRICE_BITS-1:0];
   endfunction

   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign cur_idx    = idx_ff[LW-1:0];
   assign idx_next   = idx_ff + CW'(1);
   assign px_wide    = EW'(px_ff);
   assign up_price   = lp_ff + EW'(grid_spacing);
   // first tick of the grid seeds held bits from the price
   assign held_now   = init_ff ? (lp_ff < px_wide) : held_ff[cur_idx];
   assign emit_sell  = held_now && (idx_next != level_total) && (px_wide >= up_price);
   assign emit_buy   = !held_now && (px_wide <= lp_ff);
   assign profit_sum = {1'b0, profit_ff} + {1'b0, gain_ff};
   // output register takes a new item this cycle
   assign rsp_load   = slot_free && (((state_ff == ST_WALK) && (emit_sell || emit_buy)) ||
                                     (state_ff == ST_FINAL));

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   // profit per sell fill, registered from the configured spacing and lot
   always_ff @(posedge clock) begin
      gain_ff <= 64'(grid_spacing * grid_lot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         active_ff     <= 1'b0;
         init_ff       <= 1'b0;
         profit_ff     <= '0;
         trades_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  if (q_cmd.is_fill) begin
                     if (trades_ff != '1) begin
                        trades_ff <= trades_ff + 32'd1;
                     end
                     held_ff[q_level] <= !q_cmd.sell;
                     if (q_cmd.sell) begin
                        profit_ff <= profit_sum[64] ? '1 : profit_sum[63:0];
                     end
                  end else begin
                     px_ff     <= q_price;
                     lp_ff     <= EW'(grid_lower);
                     idx_ff    <= '0;
                     init_ff   <= !active_ff;
                     active_ff <= 1'b1;
                     state_ff  <= (level_total == '0) ? ST_FINAL : ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               if (slot_free) begin
                  if (emit_sell || emit_buy) begin
                     kind_ff     <= emit_sell ? gole_pkg::KIND_SELL : gole_pkg::KIND_BUY;
                     last_ff     <= 1'b0;
                     level_ff    <= 5'(idx_ff);
                     price_ff    <= sat_price(emit_sell ? up_price : lp_ff);
                     qty_ff      <= grid_lot;
                     prof_out_ff <= '0;
                     trad_out_ff <= '0;
                  end
                  held_ff[cur_idx] <= held_now;
                  idx_ff           <= idx_next;
                  lp_ff            <= up_price;
                  if (idx_next == level_total) begin
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               if (slot_free) begin
                  kind_ff     <= gole_pkg::KIND_END;
                  last_ff     <= 1'b1;
                  level_ff    <= '0;
                  price_ff    <= '0;
                  qty_ff      <= '0;
                  prof_out_ff <= profit_ff;
                  trad_out_ff <= trades_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid       = rsp_tvalid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_last         = last_ff;
   assign rsp_level_index  = level_ff;
   assign rsp_order_price  = price_ff;
   assign rsp_quantity     = qty_ff;
   assign rsp_total_profit = prof_out_ff;
   assign rsp_total_trades = trad_out_ff;

   `ASSERT_IMPLIES(a_walk_in_range, clock, reset, state_ff == ST_WALK, idx_ff < level_total)
   `ASSERT_IMPLIES(a_last_is_end, clock, reset, rsp_tvalid_ff && last_ff, kind_ff == gole_pkg::KIND_END)
   `ASSERT_IMPLIES(a_busy_active, clock, reset, state_ff != ST_IDLE, active_ff)

endmodule

`default_nettype wire

@@ rtl/grid_order_level_engine.sv @@
// ----------------------------------------------------------------------------
// grid_order_level_engine
// price grid order engine: level occupancy, buy/sell intents and totals
// ----------------------------------------------------------------------------
//
// channel  dir  handshake            contents
// req_     in   req_tvalid/tready    tuser mode, tdata price/fill_side/fill_level
// rsp_     out  rsp_tvalid/tready    tuser kind, tlast end of plan, tdata intent
// csr_     in   csr_valid/ready      csr_index register, csr_data value
//
// a fill enters the queue at its transfer and updates state once the idle back pops it
// a tick walks its n levels (up to MAX_LEVELS) in the back engine, one level a cycle
// while rsp_ is not stalled, then emits the plan-end item
// a two-entry queue lets the front take requests while the back is walking
// reset is synchronous and clears grid state, totals and configuration
// a stalled rsp_ holds the walk; req_tready drops only when the queue is full
//
`default_nettype none

module grid_order_level_engine #(
   parameter int MAX_LEVELS = 32,
   parameter int PRICE_BITS = 40
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   input  wire logic                                    req_tuser,   // mode
   // price, fill_side, fill_level (lowest first)
   input  wire logic [((PRICE_BITS+8+7)/8)*8-1:0]       req_tdata,
   // result channel
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   output logic [1:0]                                   rsp_tuser,   // kind
   output logic                                         rsp_tlast,
   // level_index, order_price, quantity, total_profit, total_trades
   output logic [((PRICE_BITS+125+7)/8)*8-1:0]          rsp_tdata,
   // configuration write channel
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [gole_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [((PRICE_BITS > 24) ? PRICE_BITS : 24)-1:0] csr_data
);

   localparam int LW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CW     = $clog2(MAX_LEVELS + 1);
   localparam int OUT_W  = ((PRICE_BITS + 125 + 7) / 8) * 8;
   localparam int QW     = 2 + LW + PRICE_BITS;

   // configuration registers
   logic [PRICE_BITS-1:0] lower_ff;
   logic [PRICE_BITS-1:0] upper_ff;
   logic [4:0]            count_ff;
   logic [PRICE_BITS-1:0] spacing_ff;
   logic [23:0]           amount_ff;

   logic                  grid_valid;
   logic [6:0]            levels_raw;
   logic [CW-1:0]         level_total;

   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   logic                  q_full;
   gole_pkg::cmd_type     f_cmd;
   logic [LW-1:0]         f_level;
   logic [PRICE_BITS-1:0] f_price;
   logic [QW-1:0]         q_din;
   logic [QW-1:0]         q_dout;
   gole_pkg::cmd_type     b_cmd;
   logic [LW-1:0]         b_level;
   logic [PRICE_BITS-1:0] b_price;

   logic [4:0]            rsp_level_index;
   logic [PRICE_BITS-1:0] rsp_order_price;
   logic [23:0]           rsp_quantity;
   logic [63:0]           rsp_total_profit;
   logic [31:0]           rsp_total_trades;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= '0;
         upper_ff   <= '0;
         count_ff   <= '0;
         spacing_ff <= '0;
         amount_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gole_pkg::CSR_LOWER:   lower_ff   <= csr_data[PRICE_BITS-1:0];
            gole_pkg::CSR_UPPER:   upper_ff   <= csr_data[PRICE_BITS-1:0];
            gole_pkg::CSR_COUNT:   count_ff   <= csr_data[4:0];
            gole_pkg::CSR_SPACING: spacing_ff <= csr_data[PRICE_BITS-1:0];
            gole_pkg::CSR_AMOUNT:  amount_ff  <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // an invalid grid has no levels; otherwise count + 1 capped at the maximum
   assign grid_valid  = (count_ff != '0) && (upper_ff > lower_ff) && (amount_ff != '0);
   assign levels_raw  = (7'(count_ff) + 7'd1 > 7'(MAX_LEVELS)) ? 7'(MAX_LEVELS)
                                                               : 7'(count_ff) + 7'd1;
   assign level_total = grid_valid ? CW'(levels_raw) : '0;

   gole_front #(
      .PRICE_BITS (PRICE_BITS),
      .LW         (LW),
      .CW         (CW)
   ) u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .in_mode       (req_tuser),
      .in_price      (req_tdata[PRICE_BITS-1:0]),
      .in_fill_side  (req_tdata[PRICE_BITS]),
      .in_fill_level (req_tdata[PRICE_BITS+7:PRICE_BITS+1]),
      .grid_lower    (lower_ff),
      .grid_upper    (upper_ff),
      .level_total   (level_total),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (f_cmd),
      .q_level       (f_level),
      .q_price       (f_price)
   );

   assign q_din = {f_cmd, f_level, f_price};

   gole_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty),
      .full  (q_full)
   );

   assign {b_cmd, b_level, b_price} = q_dout;

   gole_back #(
      .MAX_LEVELS (MAX_LEVELS),
      .PRICE_BITS (PRICE_BITS),
      .LW         (LW),
      .CW         (CW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_cmd            (b_cmd),
      .q_level          (b_level),
      .q_price          (b_price),
      .q_pop            (q_pop),
      .grid_lower       (lower_ff),
      .grid_spacing     (spacing_ff),
      .grid_lot         (amount_ff),
      .level_total      (level_total),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_kind         (rsp_tuser),
      .rsp_last         (rsp_tlast),
      .rsp_level_index  (rsp_level_index),
      .rsp_order_price  (rsp_order_price),
      .rsp_quantity     (rsp_quantity),
      .rsp_total_profit (rsp_total_profit),
      .rsp_total_trades (rsp_total_trades)
   );

   // pack result fields, lowest first, zero filled to whole bytes
   assign rsp_tdata = OUT_W'({rsp_total_trades, rsp_total_profit, rsp_quantity,
                              rsp_order_price, rsp_level_index});

endmodule

`default_nettype wire
